// ===== design/gregorian_date_add_days_defines.svh =====
// ----------------------------------------------------------------------------
// Gregorian date adder assertion macros
// Shared property forms for the checkers of the date adder.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH
`define GREGORIAN_DATE_ADD_DAYS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gda: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gda: next-cycle check failed");

`endif

// ===== design/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// Gregorian date adder package
// Field widths, word types, datapath constants and the microcode program.
// ----------------------------------------------------------------------------
package gda_pkg;

  // Field widths.
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 16;
  localparam int unsigned WdayW  = 3;

  // Year split into century and year of century.
  localparam int unsigned YocW  = 7;
  localparam int unsigned CentW = 8;

  // Shared product register and the Zeller sum.
  localparam int unsigned ProdW = 27;
  localparam int unsigned AccW  = 11;

  // Step counter of the sequencer.
  localparam int unsigned StepW = 4;

  localparam logic [YearW-1:0] YearMin = YearW'(1900);

  // Divide by 100 as (y * 5243) >> 19, exact for every 14-bit year.
  localparam logic [12:0]  Recip100      = 13'd5243;
  localparam int unsigned  Recip100Shift = 19;
  localparam logic [YocW-1:0] YocLast    = YocW'(99);

  // Divide by 7 as (x * 2341) >> 14, exact for sums below 5461.
  localparam logic [11:0]  Recip7      = 12'd2341;
  localparam int unsigned  Recip7Shift = 14;

  localparam logic [MonW-1:0] MonJan = MonW'(1);
  localparam logic [MonW-1:0] MonFeb = MonW'(2);
  localparam logic [MonW-1:0] MonMar = MonW'(3);
  localparam logic [MonW-1:0] MonDec = MonW'(12);

  // Weekday code for Saturday.
  localparam logic [WdayW-1:0] WdaySat = WdayW'(6);

  // Jump targets of the microcode program.
  localparam logic [StepW-1:0] StepIdle    = StepW'(0);
  localparam logic [StepW-1:0] StepAdvance = StepW'(14);
  localparam logic [StepW-1:0] StepDone    = StepW'(15);

  typedef struct packed {
    logic [DayW-1:0]   day_in;
    logic [MonW-1:0]   month_in;
    logic [YearW-1:0]  year_in;
    logic [CountW-1:0] days_to_add;
  } gda_in_t;

  typedef struct packed {
    logic              date_valid;
    logic [WdayW-1:0]  weekday;
    logic [DayW-1:0]   day_out;
    logic [MonW-1:0]   month_out;
    logic [YearW-1:0]  year_out;
  } gda_out_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_LOAD  = 4'd0,
    OP_DIV   = 4'd1,
    OP_CENT  = 4'd2,
    OP_YOC   = 4'd3,
    OP_CHECK = 4'd4,
    OP_ZSUM  = 4'd5,
    OP_ZMUL  = 4'd6,
    OP_ZMOD  = 4'd7,
    OP_ADV   = 4'd8,
    OP_DONE  = 4'd9
  } gda_op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_NO_INPUT = 3'd1,
    COND_INVALID  = 3'd2,
    COND_NOT_FIT  = 3'd3,
    COND_OUT_BUSY = 3'd4
  } gda_cond_e;

  // Year source for the century split.
  typedef enum logic {
    YSEL_YEAR   = 1'b0,
    YSEL_ZELLER = 1'b1
  } gda_ysel_e;

  typedef struct packed {
    gda_op_e          op;
    gda_cond_e        cond;
    gda_ysel_e        ysel;
    logic [StepW-1:0] target;
  } gda_uword_t;

  // Control from the sequencer to the datapath and the port logic.
  typedef struct packed {
    gda_op_e   op;
    gda_ysel_e ysel;
    logic      load;
    logic      emit;
    logic      idle;
  } gda_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic date_ok;
    logic fit;
  } gda_stat_t;

  // Microcode program, one control word per step.
  function automatic gda_uword_t gda_ucode(input logic [StepW-1:0] step);
    gda_uword_t uw;
    uw = '{OP_DONE, COND_NEXT, YSEL_YEAR, StepIdle};
    case (step)
      StepW'(0):  uw = '{OP_LOAD,  COND_NO_INPUT, YSEL_YEAR,   StepIdle};
      StepW'(1):  uw = '{OP_DIV,   COND_NEXT,     YSEL_YEAR,   StepIdle};
      StepW'(2):  uw = '{OP_CENT,  COND_NEXT,     YSEL_YEAR,   StepIdle};
      StepW'(3):  uw = '{OP_YOC,   COND_NEXT,     YSEL_YEAR,   StepIdle};
      StepW'(4):  uw = '{OP_CHECK, COND_INVALID,  YSEL_YEAR,   StepDone};
      StepW'(5):  uw = '{OP_DIV,   COND_NEXT,     YSEL_ZELLER, StepIdle};
      StepW'(6):  uw = '{OP_CENT,  COND_NEXT,     YSEL_ZELLER, StepIdle};
      StepW'(7):  uw = '{OP_YOC,   COND_NEXT,     YSEL_ZELLER, StepIdle};
      StepW'(8):  uw = '{OP_ZSUM,  COND_NEXT,     YSEL_YEAR,   StepIdle};
      StepW'(9):  uw = '{OP_ZMUL,  COND_NEXT,     YSEL_YEAR,   StepIdle};
      StepW'(10): uw = '{OP_ZMOD,  COND_NEXT,     YSEL_YEAR,   StepIdle};
      StepW'(11): uw = '{OP_DIV,   COND_NEXT,     YSEL_YEAR,   StepIdle};
      StepW'(12): uw = '{OP_CENT,  COND_NEXT,     YSEL_YEAR,   StepIdle};
      StepW'(13): uw = '{OP_YOC,   COND_NEXT,     YSEL_YEAR,   StepIdle};
      StepW'(14): uw = '{OP_ADV,   COND_NOT_FIT,  YSEL_YEAR,   StepAdvance};
      StepW'(15): uw = '{OP_DONE,  COND_OUT_BUSY, YSEL_YEAR,   StepDone};
      default:    uw = '{OP_DONE,  COND_NEXT,     YSEL_YEAR,   StepIdle};
    endcase
    return uw;
  endfunction

  // Length of a month; codes outside 1 to 12 read as 31.
  function automatic logic [DayW-1:0] gda_month_len(input logic [MonW-1:0] m,
                                                    input logic leap);
    logic [DayW-1:0] n;
    case (m)
      MonW'(2):  n = leap ? DayW'(29) : DayW'(28);
      MonW'(4):  n = DayW'(30);
      MonW'(6):  n = DayW'(30);
      MonW'(9):  n = DayW'(30);
      MonW'(11): n = DayW'(30);
      default:   n = DayW'(31);
    endcase
    return n;
  endfunction

  // Zeller month term 13*(m+1)/5, with January and February as months 13 and 14.
  function automatic logic [5:0] gda_zeller_term(input logic [MonW-1:0] m);
    logic [5:0] t;
    case (m)
      MonW'(1):  t = 6'd36;
      MonW'(2):  t = 6'd39;
      MonW'(3):  t = 6'd10;
      MonW'(4):  t = 6'd13;
      MonW'(5):  t = 6'd15;
      MonW'(6):  t = 6'd18;
      MonW'(7):  t = 6'd20;
      MonW'(8):  t = 6'd23;
      MonW'(9):  t = 6'd26;
      MonW'(10): t = 6'd28;
      MonW'(11): t = 6'd31;
      MonW'(12): t = 6'd33;
      default:   t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

// ===== design/gda_seq.sv =====
// ----------------------------------------------------------------------------
// Gregorian date adder sequencer
// Step counter over the microcode program with conditional jumps.
// ----------------------------------------------------------------------------
module gda_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_busy_i,
  input  gda_pkg::gda_stat_t   stat_i,
  output gda_pkg::gda_ctrl_t   ctrl_o
);

  logic [gda_pkg::StepW-1:0] step_q, step_d;
  gda_pkg::gda_uword_t       uword;
  logic                      jump;

  // Fetch the control word of the current step.
  assign uword = gda_pkg::gda_ucode(step_q);

  // Evaluate the jump condition of this step.
  always_comb begin
    case (uword.cond)
      gda_pkg::COND_NEXT:     jump = 1'b0;
      gda_pkg::COND_NO_INPUT: jump = !in_valid_i;
      gda_pkg::COND_INVALID:  jump = !stat_i.date_ok;
      gda_pkg::COND_NOT_FIT:  jump = !stat_i.fit;
      gda_pkg::COND_OUT_BUSY: jump = out_busy_i;
      default:                jump = 1'b0;
    endcase
  end

  // The last step falls through to the idle step by wrapping.
  assign step_d = jump ? uword.target : step_q + gda_pkg::StepW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= gda_pkg::StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

  // Decode the control word for the datapath and the port logic.
  always_comb begin
    ctrl_o.op   = uword.op;
    ctrl_o.ysel = uword.ysel;
    ctrl_o.idle = (uword.op == gda_pkg::OP_LOAD);
    ctrl_o.load = (uword.op == gda_pkg::OP_LOAD) && in_valid_i;
    ctrl_o.emit = (uword.op == gda_pkg::OP_DONE) && !out_busy_i;
  end

endmodule

// ===== design/gda_datapath.sv =====
// ----------------------------------------------------------------------------
// Gregorian date adder datapath
// Date registers, century split, Zeller weekday and the month-step adder.
// ----------------------------------------------------------------------------
module gda_datapath (
  input  logic                 clk_i,
  input  gda_pkg::gda_ctrl_t   ctrl_i,
  input  gda_pkg::gda_in_t     in_data_i,
  output gda_pkg::gda_stat_t   stat_o,
  output gda_pkg::gda_out_t    res_o
);

  typedef logic [gda_pkg::ProdW-1:0]  prod_t;
  typedef logic [gda_pkg::AccW-1:0]   acc_t;
  typedef logic [gda_pkg::YearW-1:0]  year_t;
  typedef logic [gda_pkg::CountW:0]   cnt_ext_t;

  logic [gda_pkg::DayW-1:0]   day_q;
  logic [gda_pkg::MonW-1:0]   month_q;
  year_t                      year_q;
  logic [gda_pkg::CountW-1:0] left_q;
  logic [gda_pkg::YocW-1:0]   yoc_q;
  logic [gda_pkg::CentW-1:0]  cent_q;
  prod_t                      prod_q;
  acc_t                       acc_q;
  logic                       valid_q;
  logic [gda_pkg::WdayW-1:0]  wday_q;

  year_t                      src_year;
  year_t                      yoc_full;
  logic                       leap;
  logic [gda_pkg::DayW-1:0]   dim;
  logic                       date_ok;
  logic                       fit;
  acc_t                       zsum;
  logic [8:0]                 quot7;
  acc_t                       rem_full;
  logic [gda_pkg::WdayW-1:0]  rem7;
  logic [gda_pkg::WdayW-1:0]  wday_new;

  // Year fed to the century split; Zeller counts January and February
  // as months of the year before.
  assign src_year = (ctrl_i.ysel == gda_pkg::YSEL_ZELLER && month_q < gda_pkg::MonMar)
                    ? year_q - year_t'(1) : year_q;

  // Year of century from the split year and the century just found.
  assign yoc_full = src_year - year_t'(cent_q) * year_t'(100);

  // Leap rule on the split year: every fourth year, centuries only every fourth.
  assign leap = (yoc_q[1:0] == 2'b00) &&
                ((yoc_q != '0) || (cent_q[1:0] == 2'b00));

  assign dim = gda_pkg::gda_month_len(month_q, leap);

  // Validity of the loaded date.
  assign date_ok = (year_q >= gda_pkg::YearMin) &&
                   (month_q >= gda_pkg::MonJan) && (month_q <= gda_pkg::MonDec) &&
                   (day_q != '0) && (day_q <= dim);

  // The remaining days end inside the current month.
  assign fit = (cnt_ext_t'(day_q) + cnt_ext_t'(left_q)) <= cnt_ext_t'(dim);

  // Zeller sum: d + 13(m+1)/5 + k + k/4 + c/4 + 5c.
  assign zsum = acc_t'(day_q) + acc_t'(gda_pkg::gda_zeller_term(month_q)) +
                acc_t'(yoc_q) + acc_t'(yoc_q >> 2) +
                acc_t'(cent_q >> 2) + acc_t'(cent_q) * acc_t'(5);

  // Remainder by 7 from the registered reciprocal product.
  assign quot7    = prod_q[gda_pkg::Recip7Shift +: 9];
  assign rem_full = acc_q - acc_t'(quot7) * acc_t'(7);
  assign rem7     = rem_full[gda_pkg::WdayW-1:0];
  // Zeller gives Saturday as 0; shift so that Sunday is 0.
  assign wday_new = (rem7 == '0) ? gda_pkg::WdaySat : rem7 - gda_pkg::WdayW'(1);

  // Datapath registers, one operation per step.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      gda_pkg::OP_LOAD: begin
        if (ctrl_i.load) begin
          day_q   <= in_data_i.day_in;
          month_q <= in_data_i.month_in;
          year_q  <= in_data_i.year_in;
          left_q  <= in_data_i.days_to_add;
          valid_q <= 1'b0;
          wday_q  <= '0;
        end
      end
      gda_pkg::OP_DIV: begin
        prod_q <= prod_t'(src_year) * prod_t'(gda_pkg::Recip100);
      end
      gda_pkg::OP_CENT: begin
        cent_q <= prod_q[gda_pkg::Recip100Shift +: gda_pkg::CentW];
      end
      gda_pkg::OP_YOC: begin
        yoc_q <= yoc_full[gda_pkg::YocW-1:0];
      end
      gda_pkg::OP_CHECK: begin
        valid_q <= date_ok;
      end
      gda_pkg::OP_ZSUM: begin
        acc_q <= zsum;
      end
      gda_pkg::OP_ZMUL: begin
        prod_q <= prod_t'(acc_q) * prod_t'(gda_pkg::Recip7);
      end
      gda_pkg::OP_ZMOD: begin
        wday_q <= wday_new;
      end
      gda_pkg::OP_ADV: begin
        if (fit) begin
          day_q  <= day_q + left_q[gda_pkg::DayW-1:0];
          left_q <= '0;
        end else begin
          // Consume the rest of this month and move to the first of the next.
          left_q <= left_q - gda_pkg::CountW'(dim - day_q + gda_pkg::DayW'(1));
          day_q  <= gda_pkg::DayW'(1);
          if (month_q == gda_pkg::MonDec) begin
            month_q <= gda_pkg::MonJan;
            year_q  <= year_q + year_t'(1);
            if (yoc_q == gda_pkg::YocLast) begin
              yoc_q  <= '0;
              cent_q <= cent_q + gda_pkg::CentW'(1);
            end else begin
              yoc_q <= yoc_q + gda_pkg::YocW'(1);
            end
          end else begin
            month_q <= month_q + gda_pkg::MonW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.date_ok = date_ok;
  assign stat_o.fit     = fit;

  assign res_o.date_valid = valid_q;
  assign res_o.weekday    = wday_q;
  assign res_o.day_out    = day_q;
  assign res_o.month_out  = month_q;
  assign res_o.year_out   = year_q;

endmodule

// ===== design/gregorian_date_add_days.sv =====
// Steps per word: load, century split, date check, Zeller weekday, then the month-step
// loop of the sequencer, once per month end crossed; an invalid date jumps to the done step.
// The block works on one word at a time: a new word is accepted only once the last is emitted.
// A finished word waits in the output register while the next word is accepted.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
// Gregorian date adder
// Checks a date and, if it is valid, gives its weekday and advances it by a day count, one month
// per cycle, under a microcoded sequencer.
// ----------------------------------------------------------------------------
module gregorian_date_add_days (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gda_pkg::gda_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gda_pkg::gda_out_t out_data_o
);

  gda_pkg::gda_ctrl_t ctrl;
  gda_pkg::gda_stat_t stat;
  gda_pkg::gda_out_t  res;
  logic               out_valid_q;
  gda_pkg::gda_out_t  out_data_q;
  logic               out_busy;

  // The output register is busy while its word is held back.
  assign out_busy = out_valid_q && out_stall_i;

  gda_seq u_gda_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  gda_datapath u_gda_datapath (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .in_data_i (in_data_i),
    .stat_o    (stat),
    .res_o     (res)
  );

  assign in_stall_o = !ctrl.idle;

  // Output word valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/gda_checker.sv =====
// ----------------------------------------------------------------------------
// Gregorian date adder checker
// Port-level properties of the date adder, bound to the top level.
// ----------------------------------------------------------------------------
`include "gregorian_date_add_days_defines.svh"

module gda_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input gda_pkg::gda_out_t out_data_o
);

  // A held output word stays valid and unchanged.
  `GDA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // An invalid date reports a zero weekday.
  `GDA_ASSERT_NOW(a_invalid_wday, clk_i, rst_ni, out_valid_o && !out_data_o.date_valid, out_data_o.weekday == '0)

  // A valid date advances to a real day, month and weekday.
  `GDA_ASSERT_NOW(a_valid_range, clk_i, rst_ni, out_valid_o && out_data_o.date_valid, (out_data_o.day_out != '0) && (out_data_o.month_out >= gda_pkg::MonJan) && (out_data_o.month_out <= gda_pkg::MonDec) && (out_data_o.weekday <= gda_pkg::WdaySat))

  // The block works on one word at a time, so it stalls right after an accept.
  `GDA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind gregorian_date_add_days gda_checker u_gda_checker (.*);
